/* rtl/core/sgmpca_pkg.sv */
// Shared types and constants for the SGM path cost aggregation block.
// No dependencies; used by sgmpca_ctrl, sgmpca_datapath and the top level.
package sgmpca_pkg;

    // Disparity store geometry
    localparam int MAX_DISP = 64;
    localparam int ADDR_W   = $clog2(MAX_DISP);
    localparam int COUNT_W  = 7;

    // Field widths
    localparam int COST_W = 8;
    localparam int GRAY_W = 8;
    localparam int P2_W   = 12;
    localparam int CFG_W  = 12;

    // P2 divider: one quotient bit per step
    localparam int DIV_STEPS = P2_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_P1    = 2'd0;
    localparam logic [1:0] CFG_P2    = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [COST_W-1:0]  P1_RESET    = 8'd10;
    localparam logic [P2_W-1:0]    P2_RESET    = 12'd150;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    localparam logic [COST_W-1:0] COST_MAX = 8'hFF;

    typedef struct packed {
        logic [COST_W-1:0] match_cost;
        logic [5:0]        disparity_index;
        logic [GRAY_W-1:0] pixel_gray;
        logic              path_start;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] aggregated_cost;
        logic [COST_W-1:0] pixel_min_cost;
        logic              pixel_done;
    } out_item_t;

    typedef struct packed {
        logic [COST_W-1:0]  p1_penalty;
        logic [P2_W-1:0]    p2_base;
        logic [COUNT_W-1:0] disparity_count;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic pen_load;
        logic commit;
    } cmd_t;

    // Datapath to controller, decoded from the incoming item
    typedef struct packed {
        logic in_range;
        logic first;
    } status_t;

endpackage

/* rtl/core/sgmpca_ctrl.sv */
// Sequencer for the SGM path cost aggregation block.
// Depends on sgmpca_pkg; drives the command struct of sgmpca_datapath.
module sgmpca_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sgmpca_pkg::status_t st,
    output sgmpca_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PEN  = 2'd2;
    localparam logic [1:0] ST_CALC = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [sgmpca_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = (st.in_range && st.first) ? ST_DIV : ST_CALC;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sgmpca_pkg::DIV_CNT_W'(sgmpca_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_PEN;
                end
            end
            ST_PEN: begin
                cmd.pen_load = 1'b1;
                state_next   = ST_CALC;
            end
            ST_CALC: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/sgmpca_datapath.sv */
// Datapath of the SGM path cost aggregation block: previous-pixel cost store,
// P2 divider, path state and output register. Depends on sgmpca_pkg.
module sgmpca_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sgmpca_pkg::cfg_t      cfg,
    input  sgmpca_pkg::in_item_t  s_data,
    input  sgmpca_pkg::cmd_t      cmd,
    output sgmpca_pkg::status_t   st,
    output sgmpca_pkg::out_item_t m_data
);

    localparam int CW = sgmpca_pkg::COST_W;
    localparam int AW = sgmpca_pkg::ADDR_W;
    localparam int NW = sgmpca_pkg::COUNT_W;
    localparam int PW = sgmpca_pkg::P2_W;
    localparam int SW = PW + 1;

    // Previous pixel costs
    logic [CW-1:0] mem [sgmpca_pkg::MAX_DISP];
    logic [CW-1:0] rd_cur_reg, rd_up_reg;

    sgmpca_pkg::in_item_t  item_reg;
    sgmpca_pkg::out_item_t out_reg, out_next;
    logic                  in_range_reg;

    // Path state
    logic [CW-1:0] held_lower_reg, prev_min_reg, run_min_reg;
    logic [CW-1:0] prev_gray_reg;
    logic [PW-1:0] penalty_reg;

    // Divider
    logic [PW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [CW:0]   dsr_reg;
    logic [CW:0]   trial;
    logic          trial_ge;

    logic [NW-1:0] count;
    logic [NW-1:0] d_in, d_cur;
    logic [CW-1:0] gray_diff;
    logic [AW-1:0] addr_up;

    logic          first, upper_ok, done;
    logic [CW-1:0] lower, upper, side_min;
    logic [CW:0]   side_cost;
    logic [SW-1:0] jump_cost, best;
    logic [CW-1:0] result, run_min_new;

    // Active disparity count, clamped to 1..MAX_DISP
    always_comb begin
        count = cfg.disparity_count;
        if (count == '0) begin
            count = NW'(1);
        end else if (count > NW'(sgmpca_pkg::MAX_DISP)) begin
            count = NW'(sgmpca_pkg::MAX_DISP);
        end
    end

    // Decode of the incoming item
    assign d_in        = NW'(s_data.disparity_index);
    assign st.in_range = d_in < count;
    assign st.first    = (s_data.disparity_index == '0);
    assign addr_up     = AW'(s_data.disparity_index) + 1'b1;

    assign gray_diff = (s_data.pixel_gray > prev_gray_reg) ?
                       (s_data.pixel_gray - prev_gray_reg) :
                       (prev_gray_reg - s_data.pixel_gray);

    // Item capture and store reads at d and d+1
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg     <= s_data;
            in_range_reg <= st.in_range;
            rd_cur_reg   <= mem[AW'(s_data.disparity_index)];
            rd_up_reg    <= mem[addr_up];
        end
    end

    // Restoring divider: P2 / (|gray diff| + 1)
    assign trial    = {rem_reg, quo_reg[PW-1]};
    assign trial_ge = trial >= dsr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            quo_reg <= cfg.p2_base;
            rem_reg <= '0;
            dsr_reg <= {1'b0, gray_diff} + (CW+1)'(1);
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[PW-2:0], trial_ge};
            rem_reg <= trial_ge ? CW'(trial - dsr_reg) : trial[CW-1:0];
        end
    end

    // Cost recurrence for the captured item
    assign d_cur    = NW'(item_reg.disparity_index);
    assign first    = (item_reg.disparity_index == '0);
    assign upper_ok = (d_cur + 1'b1) < count;
    assign done     = (d_cur + 1'b1) == count;

    always_comb begin
        lower     = first ? sgmpca_pkg::COST_MAX : held_lower_reg;
        upper     = upper_ok ? rd_up_reg : sgmpca_pkg::COST_MAX;
        side_min  = (lower < upper) ? lower : upper;
        side_cost = {1'b0, side_min} + {1'b0, cfg.p1_penalty};
        jump_cost = SW'(prev_min_reg) + SW'(penalty_reg);
        best      = SW'(rd_cur_reg);
        if (SW'(side_cost) < best) begin
            best = SW'(side_cost);
        end
        if (jump_cost < best) begin
            best = jump_cost;
        end
        if (item_reg.path_start) begin
            result = item_reg.match_cost;
        end else begin
            result = item_reg.match_cost + best[CW-1:0] - prev_min_reg;
        end
        run_min_new = (first || result < run_min_reg) ? result : run_min_reg;
    end

    // Result item; all zero for an index beyond the count
    always_comb begin
        out_next = '0;
        if (in_range_reg) begin
            out_next.aggregated_cost = result;
            out_next.pixel_done      = done;
            out_next.pixel_min_cost  = done ? run_min_new : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    // Store write-back
    always_ff @(posedge aclk) begin
        if (cmd.commit && in_range_reg) begin
            mem[AW'(item_reg.disparity_index)] <= result;
        end
    end

    // Path state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lower_reg <= sgmpca_pkg::COST_MAX;
            prev_min_reg   <= sgmpca_pkg::COST_MAX;
            run_min_reg    <= sgmpca_pkg::COST_MAX;
            prev_gray_reg  <= '0;
            penalty_reg    <= '0;
        end else begin
            if (cmd.pen_load) begin
                penalty_reg <= (quo_reg > PW'(cfg.p1_penalty)) ? quo_reg : PW'(cfg.p1_penalty);
            end
            if (cmd.commit && in_range_reg) begin
                held_lower_reg <= rd_cur_reg;
                run_min_reg    <= run_min_new;
                if (done) begin
                    prev_min_reg  <= run_min_new;
                    prev_gray_reg <= item_reg.pixel_gray;
                end
            end
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/core/sgm_path_cost_aggregation.sv */
// Top level of the SGM path cost aggregation block: configuration registers,
// sequencer and datapath. Depends on sgmpca_pkg, sgmpca_ctrl, sgmpca_datapath.
//
// One item is one matching cost of one pixel at one disparity; each item yields
// one result item. Items are taken one at a time; on acceptance the store of
// previous-pixel costs is read at d and d+1. An item at disparity 0 then runs a
// 12-step bit-serial divider that forms the P2 penalty for the pixel, and the
// penalty is loaded. Each item is computed and written back when the output
// register is free; a waiting result does not block acceptance of the next item.
// Configuration writes (p1_penalty, p2_base, disparity_count) are taken at any
// time but are meant for idle periods.
module sgm_path_cost_aggregation (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sgmpca_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sgmpca_pkg::out_item_t m_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [sgmpca_pkg::CFG_W-1:0] cfg_data
);

    sgmpca_pkg::cfg_t    cfg_reg, cfg_next;
    sgmpca_pkg::cmd_t    cmd;
    sgmpca_pkg::status_t st;

    // Configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                sgmpca_pkg::CFG_P1: begin
                    cfg_next.p1_penalty = cfg_data[sgmpca_pkg::COST_W-1:0];
                end
                sgmpca_pkg::CFG_P2: begin
                    cfg_next.p2_base = cfg_data[sgmpca_pkg::P2_W-1:0];
                end
                sgmpca_pkg::CFG_COUNT: begin
                    cfg_next.disparity_count = cfg_data[sgmpca_pkg::COUNT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.p1_penalty      <= sgmpca_pkg::P1_RESET;
            cfg_reg.p2_base         <= sgmpca_pkg::P2_RESET;
            cfg_reg.disparity_count <= sgmpca_pkg::COUNT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sgmpca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    sgmpca_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_data  (m_data)
    );

endmodule

/* test/sgmpca_checker.sv */
// Scoreboard for the SGM path cost aggregation block: watches the item channels
// and the register port, predicts every result and compares it field by field.
// Depends on sgmpca_pkg.
module sgmpca_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  sgmpca_pkg::in_item_t          s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  sgmpca_pkg::out_item_t         m_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [sgmpca_pkg::CFG_W-1:0]  cfg_data,
    output int                            n_errors,
    output int                            n_pending
);
    import sgmpca_pkg::*;

    // Register copies
    logic [COST_W-1:0]  p1_reg;
    logic [P2_W-1:0]    p2_reg;
    logic [COUNT_W-1:0] count_reg;

    // Path state of the predictor
    logic [COST_W-1:0] prior_cost [MAX_DISP];
    logic [COST_W-1:0] lower_hold;
    logic [COST_W-1:0] prior_min;
    logic [COST_W-1:0] pixel_min;
    logic [GRAY_W-1:0] prior_gray;
    logic [P2_W-1:0]   pen_latch;

    out_item_t expected_costs [$];

    task automatic log_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // Aggregates one cost item and, for an index within the count, advances the path state
    function automatic out_item_t aggregate_step(input in_item_t it);
        out_item_t   res;
        int unsigned n, d, gray, pgray, diff, quot, p1;
        int unsigned old_cost, lower, upper, best, pmin, agg;
        res  = '0;
        n    = (count_reg == 0) ? 1 : ((count_reg > MAX_DISP) ? MAX_DISP : count_reg);
        d    = it.disparity_index;
        gray = it.pixel_gray;
        p1   = p1_reg;
        if (d >= n)
            return res;

        // penalty is formed on disparity 0 and held for the pixel
        if (d == 0) begin
            pgray = prior_gray;
            diff  = (gray > pgray) ? gray - pgray : pgray - gray;
            quot  = p2_reg / (diff + 1);
            pen_latch = P2_W'((quot > p1) ? quot : p1);
        end

        old_cost = prior_cost[d];
        pmin     = prior_min;
        if (it.path_start) begin
            agg = it.match_cost;
        end else begin
            lower = (d == 0) ? 255 : lower_hold;
            upper = (d + 1 < n) ? prior_cost[d + 1] : 255;
            best  = old_cost;
            if (lower + p1 < best)
                best = lower + p1;
            if (upper + p1 < best)
                best = upper + p1;
            if (pmin + pen_latch < best)
                best = pmin + pen_latch;
            agg = (it.match_cost + ((best - pmin) & 255)) & 255;
        end

        lower_hold    = old_cost[COST_W-1:0];
        prior_cost[d] = agg[COST_W-1:0];
        if (d == 0 || agg < pixel_min)
            pixel_min = agg[COST_W-1:0];

        res.aggregated_cost = agg[COST_W-1:0];
        if (d + 1 == n) begin
            prior_min          = pixel_min;
            prior_gray         = it.pixel_gray;
            res.pixel_min_cost = pixel_min;
            res.pixel_done     = 1'b1;
        end
        return res;
    endfunction

    // Prediction on accepted input items, comparison on accepted results
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            p1_reg     = P1_RESET;
            p2_reg     = P2_RESET;
            count_reg  = COUNT_RESET;
            lower_hold = COST_MAX;
            prior_min  = COST_MAX;
            pixel_min  = COST_MAX;
            prior_gray = '0;
            pen_latch  = '0;
            for (int i = 0; i < MAX_DISP; i++)
                prior_cost[i] = '0;
            expected_costs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_P1:    p1_reg    = cfg_data[COST_W-1:0];
                    CFG_P2:    p2_reg    = cfg_data[P2_W-1:0];
                    CFG_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_costs.insert(expected_costs.size(), aggregate_step(s_data));
            if (m_valid && m_ready) begin
                if (expected_costs.size() == 0) begin
                    log_mismatch($sformatf("result with nothing expected, cost %0d",
                                           m_data.aggregated_cost));
                end else begin
                    want = expected_costs.pop_front();
                    if (m_data.aggregated_cost !== want.aggregated_cost)
                        log_mismatch($sformatf("aggregated_cost expected %0d got %0d",
                                               want.aggregated_cost, m_data.aggregated_cost));
                    if (m_data.pixel_min_cost !== want.pixel_min_cost)
                        log_mismatch($sformatf("pixel_min_cost expected %0d got %0d",
                                               want.pixel_min_cost, m_data.pixel_min_cost));
                    if (m_data.pixel_done !== want.pixel_done)
                        log_mismatch($sformatf("pixel_done expected %0d got %0d",
                                               want.pixel_done, m_data.pixel_done));
                end
            end
        end
        n_pending <= expected_costs.size();
    end

endmodule

/* test/sgm_path_cost_aggregation_tb.sv */
// Testbench top for sgm_path_cost_aggregation: clock, reset, register writes,
// cost item stimulus, result back-pressure and the verdict.
// Depends on sgmpca_pkg, sgm_path_cost_aggregation and sgmpca_checker.
module sgm_path_cost_aggregation_tb;
    import sgmpca_pkg::*;

    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 90;
    localparam int HOLD_PHASE     = 3;
    localparam int QUIET_PHASE    = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int n_errors;
    int n_pending;
    int phase_no;
    int idle_cycles;
    int cur_count;
    logic quiet;

    assign quiet = (phase_no == QUIET_PHASE);

    sgm_path_cost_aggregation u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sgmpca_checker u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: cycles in which nothing moves on any port
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (phase_no == HOLD_PHASE && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= 32);
        end
    end

    function automatic in_item_t make_item(input logic [7:0] cost, input logic [5:0] d,
                                           input logic [7:0] gray, input logic start);
        in_item_t it;
        it.match_cost      = cost;
        it.disparity_index = d;
        it.pixel_gray      = gray;
        it.path_start      = start;
        return it;
    endfunction

    // Byte with extra weight on both ends of the range
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Offers one cost item and returns at the edge that accepts it
    task automatic feed_cost(input in_item_t it);
        while (!quiet && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // First len disparities of one pixel, in order
    task automatic feed_pixel(input logic start, input logic [7:0] gray, input int len);
        for (int i = 0; i < len; i++)
            feed_cost(make_item(pick_byte(), 6'(i), gray, start));
    endtask

    // Stops offering and waits until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0)
            @(posedge aclk);
    endtask

    // Writes all three registers; unused upper data bits get noise
    task automatic load_settings(input int unsigned p1, input int unsigned p2,
                                 input int unsigned cnt);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_P1;
        cfg_data  <= {4'($urandom), 8'(p1)};
        @(posedge aclk);
        cfg_index <= CFG_P2;
        cfg_data  <= CFG_W'(p2);
        @(posedge aclk);
        cfg_index <= CFG_COUNT;
        cfg_data  <= {5'($urandom), 7'(cnt)};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_count = (7'(cnt) == 0) ? 1 : ((7'(cnt) > MAX_DISP) ? MAX_DISP : 7'(cnt));
    endtask

    // Stimulus and verdict
    initial begin
        int unsigned p1, p2, cnt, fed, r;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_P1;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        phase_no  <= 0;
        cur_count = MAX_DISP;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full start pixel fills the whole store, then one full follow-on pixel
        feed_pixel(1'b1, 8'd0, MAX_DISP);
        feed_pixel(1'b0, 8'hFF, MAX_DISP);
        settle();

        // largest penalties, three disparities, indexes past the count
        load_settings(255, 4095, 3);
        feed_cost(make_item(8'hFF, 6'd0, 8'hFF, 1'b1));
        feed_cost(make_item(8'hFF, 6'd1, 8'hFF, 1'b1));
        feed_cost(make_item(8'd0, 6'd2, 8'hFF, 1'b1));
        feed_cost(make_item(8'd0, 6'd0, 8'd0, 1'b0));
        feed_cost(make_item(8'hFF, 6'd1, 8'd0, 1'b0));
        feed_cost(make_item(8'd128, 6'd2, 8'd0, 1'b0));
        feed_cost(make_item(8'd7, 6'd3, 8'd0, 1'b0));
        feed_cost(make_item(8'd200, 6'd63, 8'hFF, 1'b1));
        feed_cost(make_item(8'hFF, 6'd0, 8'hFF, 1'b0));
        feed_cost(make_item(8'hFF, 6'd1, 8'hFF, 1'b0));
        feed_cost(make_item(8'hFF, 6'd2, 8'hFF, 1'b0));
        settle();

        // zero penalties, single disparity
        load_settings(0, 0, 1);
        feed_cost(make_item(8'd5, 6'd0, 8'd100, 1'b1));
        feed_cost(make_item(8'd250, 6'd0, 8'd100, 1'b0));
        feed_cost(make_item(8'd0, 6'd0, 8'd0, 1'b0));
        settle();

        // a count of zero behaves as one
        load_settings(10, 150, 0);
        feed_cost(make_item(8'd33, 6'd0, 8'd1, 1'b0));
        feed_cost(make_item(8'd17, 6'd1, 8'd1, 1'b0));
        settle();

        // a count above the store depth behaves as the full depth
        load_settings(1, 4095, 127);
        feed_pixel(1'b0, 8'd128, MAX_DISP);
        settle();

        // random phases: mostly well-formed pixels, some noise and cut pixels
        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            r  = $urandom_range(0, 6);
            p1 = (r == 0) ? 0 : ((r == 1) ? 255 : $urandom_range(0, 255));
            r  = $urandom_range(0, 6);
            p2 = (r == 0) ? 0 : ((r == 1) ? 4095 : $urandom_range(0, 4095));
            case ($urandom_range(0, 9))
                0:       cnt = MAX_DISP;
                1:       cnt = $urandom_range(9, MAX_DISP);
                2:       cnt = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                default: cnt = $urandom_range(1, 8);
            endcase
            load_settings(p1, p2, cnt);
            phase_no <= ph;
            fed = 0;
            while (fed < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    feed_pixel($urandom_range(0, 4) == 0, pick_byte(), cur_count);
                    fed += cur_count;
                end else if (r < 88) begin
                    cnt = $urandom_range(1, cur_count);
                    feed_pixel($urandom_range(0, 4) == 0, pick_byte(), cnt);
                    fed += cnt;
                end else begin
                    feed_cost(make_item(pick_byte(), 6'($urandom), pick_byte(),
                                        1'($urandom)));
                    fed++;
                end
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sgmpca_pkg.sv
rtl/core/sgmpca_ctrl.sv
rtl/core/sgmpca_datapath.sv
rtl/core/sgm_path_cost_aggregation.sv
test/sgmpca_checker.sv
test/sgm_path_cost_aggregation_tb.sv
